// File: hdl/acia_pkg.sv
// Shared types and constants for the serial adapter register block.
package acia_pkg;

  // Event codes carried in the op field of an input word.
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_RXBYTE = 3'd2;
  localparam logic [2:0] OP_TXDONE = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_CTS   = 3'd5;
  localparam logic [2:0] OP_DCD   = 3'd6;

  // Status bit positions.
  localparam int unsigned ST_RDRF = 0;
  localparam int unsigned ST_TDRE = 1;
  localparam int unsigned ST_DCD  = 2;
  localparam int unsigned ST_CTS  = 3;
  localparam int unsigned ST_OVRN = 5;
  localparam int unsigned ST_IRQ  = 7;

  // Control field codes.
  localparam logic [1:0] CR_MASTER_RESET = 2'b11;
  localparam logic [1:0] CR_TX_IRQ_EN    = 2'b01;
  localparam logic [1:0] CR_RTS_HIGH     = 2'b10;
  localparam int unsigned CR_RX_IRQ_EN   = 7;

  localparam logic [7:0]  STATUS_RESET   = 8'h02;
  localparam logic [15:0] TX_DELAY_RESET = 16'd160;

  typedef struct packed {
    logic [2:0]  op;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] tick_cycles;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       rts_level;
    logic       rts_toggle;
    logic [7:0] tx_byte;
    logic       tx_start;
    logic       rx_taken;
  } out_word_t;

endpackage

// File: hdl/acia_if.sv
// Valid/ready channel interfaces for the input and result words.
interface acia_in_if;
  logic              valid;
  logic              ready;
  acia_pkg::in_word_t word;

  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface acia_out_if;
  logic               valid;
  logic               ready;
  acia_pkg::out_word_t word;

  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

// File: hdl/acia_serial_registers.sv
// Serial adapter register block: event decode, state update and result register.
//
//   port        dir   handshake       payload
//   in_chan     in    valid/ready     op, rs, data, tick_cycles
//   out_chan    out   valid/ready     read_data, irq, rts_level, rts_toggle,
//                                     tx_byte, tx_start, rx_taken
//   cfg_*       in    write enable    tx_start_delay (16 bits)
//
// One word is accepted per cycle unless a held result stalls the input; its result
// appears in the output register on the next cycle, since the whole state update is
// one level of logic. The output register is the only stage: a new word is taken
// whenever the result register is empty or being drained in the same cycle.
// rst_n is synchronous and active low; it restores all state but the result word,
// including the start delay register at 160.
module acia_serial_registers (
  input  logic              clk,
  input  logic              rst_n,
  acia_in_if.sink           in_chan,
  acia_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  logic [15:0] tx_delay_r;
  logic [7:0]  ctrl_r,    ctrl_nxt;
  logic [7:0]  status_r,  status_nxt;
  logic        dcd_lat_r, dcd_lat_nxt;
  logic        st_read_r, st_read_nxt;
  logic        tx_idle_r, tx_idle_nxt;
  logic [7:0]  tx_data_r, tx_data_nxt;
  logic [7:0]  rx_data_r, rx_data_nxt;
  logic [15:0] tx_cnt_r,  tx_cnt_nxt;
  logic        rts_r,     rts_nxt;

  logic                out_valid_r, out_valid_nxt;
  acia_pkg::out_word_t out_word_r,  out_word_nxt;

  logic        accept;
  logic        irq_upd;
  logic        rx_irq;
  logic        tx_irq;
  logic [15:0] tick_left;

  acia_pkg::in_word_t iw;

  assign iw            = in_chan.word;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.word  = out_word_r;

  assign tick_left = (tx_cnt_r >= iw.tick_cycles) ? tx_cnt_r - iw.tick_cycles : 16'd0;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    status_nxt  = status_r;
    dcd_lat_nxt = dcd_lat_r;
    st_read_nxt = st_read_r;
    tx_idle_nxt = tx_idle_r;
    tx_data_nxt = tx_data_r;
    rx_data_nxt = rx_data_r;
    tx_cnt_nxt  = tx_cnt_r;
    rts_nxt     = rts_r;
    irq_upd     = 1'b0;
    out_word_nxt = '0;

    case (iw.op)
      acia_pkg::OP_READ: begin
        if (iw.rs) begin
          status_nxt[acia_pkg::ST_RDRF] = 1'b0;
          if (st_read_r) begin
            dcd_lat_nxt = 1'b0;
          end
          out_word_nxt.read_data = rx_data_r;
          out_word_nxt.rx_taken  = 1'b1;
          rx_data_nxt = 8'd0;
          irq_upd     = 1'b1;
        end else begin
          st_read_nxt = 1'b1;
          out_word_nxt.read_data = status_r;
        end
      end
      acia_pkg::OP_WRITE: begin
        if (iw.rs) begin
          if (status_r[acia_pkg::ST_TDRE]) begin
            tx_data_nxt = iw.data;
            tx_cnt_nxt  = tx_delay_r;
            tx_idle_nxt = 1'b0;
          end
          status_nxt[acia_pkg::ST_TDRE] = 1'b0;
        end else begin
          ctrl_nxt = iw.data;
          // Master reset clears everything except control, RTS and the delay setting.
          if (iw.data[1:0] == acia_pkg::CR_MASTER_RESET) begin
            status_nxt  = acia_pkg::STATUS_RESET;
            dcd_lat_nxt = 1'b0;
            st_read_nxt = 1'b0;
            tx_idle_nxt = 1'b1;
            tx_data_nxt = 8'd0;
            rx_data_nxt = 8'd0;
            tx_cnt_nxt  = 16'd0;
          end
          rts_nxt = (iw.data[6:5] == acia_pkg::CR_RTS_HIGH);
          out_word_nxt.rts_toggle = rts_nxt ^ rts_r;
        end
        irq_upd = 1'b1;
      end
      acia_pkg::OP_RXBYTE: begin
        status_nxt[acia_pkg::ST_RDRF] = 1'b1;
        rx_data_nxt = iw.data;
        irq_upd     = 1'b1;
      end
      acia_pkg::OP_TXDONE: begin
        if (!status_r[acia_pkg::ST_CTS]) begin
          status_nxt[acia_pkg::ST_TDRE] = 1'b1;
        end
        tx_idle_nxt = 1'b1;
        irq_upd     = 1'b1;
      end
      acia_pkg::OP_TICK: begin
        if (tx_cnt_r != 16'd0) begin
          tx_cnt_nxt = tick_left;
          out_word_nxt.tx_start = (tick_left == 16'd0);
        end
      end
      acia_pkg::OP_CTS: begin
        if (iw.data != 8'd0) begin
          status_nxt[acia_pkg::ST_CTS]  = 1'b1;
          status_nxt[acia_pkg::ST_TDRE] = 1'b0;
        end else begin
          status_nxt[acia_pkg::ST_CTS] = 1'b0;
          if (tx_idle_r) begin
            status_nxt[acia_pkg::ST_TDRE] = 1'b1;
          end
        end
        irq_upd = 1'b1;
      end
      acia_pkg::OP_DCD: begin
        if (iw.data != 8'd0) begin
          // Only a rising edge latches the interrupt and rearms the read sequence.
          if (!status_r[acia_pkg::ST_DCD]) begin
            dcd_lat_nxt = 1'b1;
            st_read_nxt = 1'b0;
          end
          status_nxt[acia_pkg::ST_DCD] = 1'b1;
        end else begin
          status_nxt[acia_pkg::ST_DCD] = 1'b0;
        end
        irq_upd = 1'b1;
      end
      default: begin
      end
    endcase

    rx_irq = ctrl_nxt[acia_pkg::CR_RX_IRQ_EN] &&
             (status_nxt[acia_pkg::ST_RDRF] || status_nxt[acia_pkg::ST_OVRN] || dcd_lat_nxt);
    tx_irq = (ctrl_nxt[6:5] == acia_pkg::CR_TX_IRQ_EN) && status_nxt[acia_pkg::ST_TDRE];
    if (irq_upd) begin
      status_nxt[acia_pkg::ST_IRQ] = rx_irq || tx_irq;
    end

    out_word_nxt.irq       = status_nxt[acia_pkg::ST_IRQ];
    out_word_nxt.rts_level = rts_nxt;
    out_word_nxt.tx_byte   = tx_data_nxt;
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_delay_r  <= acia_pkg::TX_DELAY_RESET;
      ctrl_r      <= 8'd0;
      status_r    <= acia_pkg::STATUS_RESET;
      dcd_lat_r   <= 1'b0;
      st_read_r   <= 1'b0;
      tx_idle_r   <= 1'b1;
      tx_data_r   <= 8'd0;
      rx_data_r   <= 8'd0;
      tx_cnt_r    <= 16'd0;
      rts_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tx_delay_r <= cfg_wdata;
      end
      if (accept) begin
        ctrl_r    <= ctrl_nxt;
        status_r  <= status_nxt;
        dcd_lat_r <= dcd_lat_nxt;
        st_read_r <= st_read_nxt;
        tx_idle_r <= tx_idle_nxt;
        tx_data_r <= tx_data_nxt;
        rx_data_r <= rx_data_nxt;
        tx_cnt_r  <= tx_cnt_nxt;
        rts_r     <= rts_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  // A data write into an empty transmit register loads the start delay.
  a_delay_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && iw.op == acia_pkg::OP_WRITE && iw.rs && status_r[acia_pkg::ST_TDRE]
    |=> tx_cnt_r == $past(tx_delay_r))
    else $error("transmit delay counter not loaded on data write");

  // The framing, overrun and parity bits are never raised.
  a_status_unused: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[6:4] == 3'b000)
    else $error("unused status bits set");

  // A held result stalls the input side.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input accepted while result register is stalled");

  // A pending result reflects the current state registers.
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.irq == status_r[acia_pkg::ST_IRQ] &&
                    out_word_r.rts_level == rts_r && out_word_r.tx_byte == tx_data_r)
    else $error("result word disagrees with state registers");

endmodule
